// ----- sv/caf_pkg.sv -----
// caf_pkg: shared types and constants of the complementary attitude filter.
// No dependencies.
`timescale 1ns / 1ps
package caf_pkg;

  localparam int TBL_BITS  = 24;
  localparam int TBL_LEN   = 24;
  localparam int ALPHA_ONE = 32768;

  // CORDIC datapath widths (operands scaled by 2^16, growth margin);
  // angle holds +-512 degrees in Q.24
  localparam int CW = 36;
  localparam int ZW = 34;

  // register byte addresses
  localparam logic [2:0] ADDR_BLEND  = 3'd0;
  localparam logic [2:0] ADDR_PERIOD = 3'd4;

  // atan(2^-i) in degrees, Q.24
  function automatic logic [ZW-1:0] atan_deg(input logic [4:0] i);
    logic [ZW-1:0] v;
    begin
      case (i)
        5'd0:  v = 34'd754974720;
        5'd1:  v = 34'd445687602;
        5'd2:  v = 34'd235489088;
        5'd3:  v = 34'd119537938;
        5'd4:  v = 34'd60000934;
        5'd5:  v = 34'd30029717;
        5'd6:  v = 34'd15018523;
        5'd7:  v = 34'd7509720;
        5'd8:  v = 34'd3754917;
        5'd9:  v = 34'd1877466;
        5'd10: v = 34'd938734;
        5'd11: v = 34'd469367;
        5'd12: v = 34'd234684;
        5'd13: v = 34'd117342;
        5'd14: v = 34'd58671;
        5'd15: v = 34'd29335;
        5'd16: v = 34'd14668;
        5'd17: v = 34'd7334;
        5'd18: v = 34'd3667;
        5'd19: v = 34'd1833;
        5'd20: v = 34'd917;
        5'd21: v = 34'd458;
        5'd22: v = 34'd229;
        5'd23: v = 34'd115;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CORD  = 5'b00010,
    ST_MUL_A = 5'b00100,
    ST_MUL_B = 5'b01000,
    ST_OUT   = 5'b10000
  } caf_state_t;

endpackage

// ----- sv/caf_imu_if.sv -----
// caf_imu_if: valid/ready channel carrying one raw six-axis IMU sample.
// Depends on nothing.
`timescale 1ns / 1ps
interface caf_imu_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  output ready);
endinterface

// ----- sv/caf_angle_if.sv -----
// caf_angle_if: valid/ready channel carrying the three updated angles.
// Depends on nothing.
`timescale 1ns / 1ps
interface caf_angle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] roll_angle;
  logic signed [31:0] pitch_angle;
  logic signed [31:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// ----- sv/caf_cordic_lane.sv -----
// caf_cordic_lane: iterative vectoring CORDIC, atan2(y,x) in degrees Q.24.
// Depends on caf_pkg.
`timescale 1ns / 1ps
module caf_cordic_lane
  import caf_pkg::*;
(
  input  logic                 clk,
  input  logic                 load,
  input  logic                 en,
  input  logic [4:0]           step,
  input  logic signed [16:0]   y_in,
  input  logic signed [16:0]   x_in,
  output logic signed [ZW-1:0] angle_q24
);

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [16:0]   xi, yi;
  logic signed [CW-1:0] xs, ys;

  // pre-rotate into the right half plane, seed with +-180 degrees;
  // iterate only while enabled, otherwise hold
  always_comb begin
    xi = x_in;
    yi = y_in;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    xs = x_r >>> step;
    ys = y_r >>> step;
    if (load) begin
      if (x_in < 0) begin
        xi = -xi;
        yi = -yi;
        z_nxt = (y_in >= 0) ? (ZW'(180) <<< TBL_BITS) : -(ZW'(180) <<< TBL_BITS);
      end else begin
        z_nxt = '0;
      end
      x_nxt = CW'(xi) <<< 16;
      y_nxt = CW'(yi) <<< 16;
    end else if (en) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + $signed(atan_deg(step));
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - $signed(atan_deg(step));
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign angle_q24 = z_r;

endmodule

// ----- sv/caf_blend.sv -----
// caf_blend: per-axis gyro integrate and alpha blend with tilt angle.
// Multiply sequence in phases A and B; depends on caf_pkg.
`timescale 1ns / 1ps
module caf_blend
  import caf_pkg::*;
#(
  parameter int FRAC = 16
) (
  input  logic               clk,
  input  logic               phase_a,
  input  logic               phase_b,
  input  logic signed [15:0] gyro,
  input  logic [23:0]        period,
  input  logic [15:0]        alpha,
  input  logic signed [31:0] est,
  input  logic signed [33:0] acc,
  output logic signed [31:0] result
);

  localparam int SH = TBL_BITS - FRAC;

  logic signed [40:0] prod_r;
  logic signed [40:0] inc_rnd;
  logic signed [33:0] ge;
  logic signed [51:0] t1_r, t2_r;
  logic signed [51:0] s;

  // first cycle: gyro times period
  always_ff @(posedge clk) begin
    if (phase_a) prod_r <= gyro * $signed({1'b0, period});
  end

  assign inc_rnd = (SH == 0) ? prod_r : (prod_r + 41'(1 <<< (SH - 1))) >>> SH;
  assign ge = 34'(est) + 34'(inc_rnd);

  // second cycle: the two weight products
  always_ff @(posedge clk) begin
    if (phase_b) begin
      t1_r <= $signed({1'b0, alpha}) * ge;
      t2_r <= $signed(17'(ALPHA_ONE) - {1'b0, alpha}) * acc;
    end
  end

  // round, floor and saturate
  always_comb begin
    s = (t1_r + t2_r + 52'sd16384) >>> 15;
    if (s > 52'sd2147483647)       result = 32'h7fffffff;
    else if (s < -52'sd2147483648) result = 32'h80000000;
    else                           result = s[31:0];
  end

endmodule

// ----- sv/complementary_attitude_filter.sv -----
// complementary_attitude_filter: top level with APB registers, sequencer and lanes.
// Depends on caf_pkg, caf_imu_if, caf_angle_if, caf_cordic_lane, caf_blend.
//
//  channel | direction | payload
//  in_     | sink      | accel_x/y/z, gyro_x/y/z (16b signed)
//  out_    | source    | roll/pitch/yaw_angle (32b signed Q16.16)
//  cfg_    | APB slave | blend_weight @0x0, sample_period @0x4
//
// Each sample passes through ST_CORD, ST_MUL_A, ST_MUL_B and ST_OUT, the
// CORDIC iteration count being shared by the two lanes; the next sample is taken
// once the result transfer completes. Synchronous active-low reset zeroes
// the angle state. The output holds while out_ready is low.
`timescale 1ns / 1ps
module complementary_attitude_filter
  import caf_pkg::*;
#(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  caf_imu_if.sink     in_ch,
  caf_angle_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NSTEP = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;
  localparam int SH    = TBL_BITS - ANGLE_FRAC_BITS;

  logic [15:0] alpha_reg_r;
  logic [23:0] period_r;
  caf_state_t  st_r, st_nxt;
  logic [4:0]  step_r;
  logic signed [31:0] roll_r, pitch_r, yaw_r;
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic signed [ZW-1:0] roll_z, pitch_z;
  logic signed [33:0] roll_acc, pitch_acc;
  logic signed [31:0] roll_new, pitch_new, yaw_new;
  logic        zr_r, zp_r;
  logic [15:0] alpha;
  logic        load;

  // configuration registers
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_reg_r <= 16'd29491;
      period_r    <= 24'd83886;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == ADDR_BLEND)  alpha_reg_r <= cfg_pwdata[15:0];
      if (cfg_paddr == ADDR_PERIOD) period_r    <= cfg_pwdata[23:0];
    end
  end
  always_comb begin
    case (cfg_paddr)
      ADDR_BLEND:  cfg_prdata = {16'b0, alpha_reg_r};
      ADDR_PERIOD: cfg_prdata = {8'b0, period_r};
      default:     cfg_prdata = '0;
    endcase
  end
  assign alpha = (alpha_reg_r > 16'(ALPHA_ONE)) ? 16'(ALPHA_ONE) : alpha_reg_r;

  assign in_ch.ready  = (st_r == ST_IDLE);
  assign out_ch.valid = (st_r == ST_OUT);
  assign load = in_ch.valid && in_ch.ready;

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (load) st_nxt = ST_CORD;
      ST_CORD:  if (32'(step_r) == NSTEP - 1) st_nxt = ST_MUL_A;
      ST_MUL_A: st_nxt = ST_MUL_B;
      ST_MUL_B: st_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // angle state takes the blended values at the result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      step_r  <= '0;
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CORD) step_r <= step_r + 5'd1;
      else                 step_r <= '0;
      if (out_ch.valid && out_ch.ready) begin
        roll_r  <= roll_new;
        pitch_r <= pitch_new;
        yaw_r   <= yaw_new;
      end
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (load) begin
      ax_r <= in_ch.accel_x; ay_r <= in_ch.accel_y; az_r <= in_ch.accel_z;
      gx_r <= in_ch.gyro_x;  gy_r <= in_ch.gyro_y;  gz_r <= in_ch.gyro_z;
      zr_r <= (in_ch.accel_y == 0) && (in_ch.accel_z == 0);
      zp_r <= (in_ch.accel_x == 0) && (in_ch.accel_z == 0);
    end
  end

  // tilt lanes; pitch takes -accel_x on 17 bits so -(-32768) stays positive
  logic signed [16:0] nax_w;
  assign nax_w = -17'(in_ch.accel_x);

  caf_cordic_lane u_roll (
    .clk(clk), .load(load), .en(st_r == ST_CORD), .step(step_r),
    .y_in(17'(in_ch.accel_y)), .x_in(17'(in_ch.accel_z)), .angle_q24(roll_z)
  );
  caf_cordic_lane u_pitch (
    .clk(clk), .load(load), .en(st_r == ST_CORD), .step(step_r),
    .y_in(nax_w), .x_in(17'(in_ch.accel_z)), .angle_q24(pitch_z)
  );

  function automatic logic signed [33:0] rnd(input logic signed [ZW-1:0] z);
    logic signed [33:0] w;
    begin
      w = 34'(z);
      if (SH > 0) w = (w + 34'(1 <<< (SH - 1))) >>> SH;
      return w;
    end
  endfunction
  assign roll_acc  = zr_r ? '0 : rnd(roll_z);
  assign pitch_acc = zp_r ? '0 : rnd(pitch_z);

  caf_blend #(.FRAC(ANGLE_FRAC_BITS)) u_broll (
    .clk(clk), .phase_a(st_r == ST_MUL_A), .phase_b(st_r == ST_MUL_B),
    .gyro(gx_r), .period(period_r), .alpha(alpha), .est(roll_r),
    .acc(roll_acc), .result(roll_new)
  );
  caf_blend #(.FRAC(ANGLE_FRAC_BITS)) u_bpitch (
    .clk(clk), .phase_a(st_r == ST_MUL_A), .phase_b(st_r == ST_MUL_B),
    .gyro(gy_r), .period(period_r), .alpha(alpha), .est(pitch_r),
    .acc(pitch_acc), .result(pitch_new)
  );
  caf_blend #(.FRAC(ANGLE_FRAC_BITS)) u_byaw (
    .clk(clk), .phase_a(st_r == ST_MUL_A), .phase_b(st_r == ST_MUL_B),
    .gyro(gz_r), .period(period_r), .alpha(alpha), .est(yaw_r),
    .acc('0), .result(yaw_new)
  );

  // blend products are held after ST_MUL_B, so the new angles stay put
  assign out_ch.roll_angle  = roll_new;
  assign out_ch.pitch_angle = pitch_new;
  assign out_ch.yaw_angle   = yaw_new;

  // checks
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.roll_angle))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while result pending");

endmodule
